>>> rtl/pqrl_pkg.sv
`default_nettype none

package pqrl_pkg;

  // Widths fixed by the transaction fields
  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 16;
  localparam int BYTES_W = 40;
  localparam int STAT_W  = 3;
  localparam int SLOT_OUT_W = 4;

  // Operation codes
  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_RATE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_COUNT = 3'd2;
  localparam logic [STAT_W-1:0] ST_BYTES = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

  // Register indexes (byte address bits [4:3])
  localparam logic [1:0] REG_MAX_RATE  = 2'd0;
  localparam logic [1:0] REG_MAX_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_BYTES = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]   MAX_RATE_RST  = 16'd10;
  localparam logic [CNT_W-1:0]   MAX_COUNT_RST = 16'd100;
  localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 40'd10485760;

  // One peer entry as kept in the table memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CNT_W-1:0]   items;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   hits;
    logic [TIME_W-1:0]  win_start;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the accepted transaction, clear the scan address
    logic rd_en;     // read the entry at the scan address
    logic addr_inc;  // advance the scan address
    logic load_hit;  // take the entry just read as the working entry
    logic load_new;  // create a fresh entry at the next free slot
    logic exec;      // apply the operation, write back, post the result
    logic full;      // post a table-full result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic key_match;
    logic last_entry;
    logic empty;
    logic table_full;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/pqrl_ctrl.sv
`default_nettype none

module pqrl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire pqrl_pkg::stat_t st,
  output pqrl_pkg::cmd_t      cmd
);
  import pqrl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_next = st.empty ? S_MISS : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.key_match) begin
          cmd.load_hit = 1'b1;
          state_next = S_EXEC;
        end else if (st.last_entry) begin
          state_next = S_MISS;
        end else begin
          cmd.addr_inc = 1'b1;
          state_next = S_READ;
        end
      end
      S_MISS: begin
        if (st.table_full) begin
          cmd.full = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.load_new = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pqrl_datapath.sv
`default_nettype none

module pqrl_datapath #(
  parameter int PEER_ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pqrl_pkg::cmd_t                    cmd,
  output pqrl_pkg::stat_t                        st,
  input  wire logic                              operation,
  input  wire logic signed [pqrl_pkg::KEY_W-1:0] peer_key,
  input  wire logic [pqrl_pkg::SIZE_W-1:0]       tx_size,
  input  wire logic [pqrl_pkg::TIME_W-1:0]       now_seconds,
  input  wire logic [pqrl_pkg::CNT_W-1:0]        rate_limit,
  input  wire logic [pqrl_pkg::CNT_W-1:0]        count_limit,
  input  wire logic [pqrl_pkg::BYTES_W-1:0]      max_bytes,
  output logic                                   done,
  output logic [pqrl_pkg::STAT_W-1:0]            status,
  output logic [pqrl_pkg::SLOT_OUT_W-1:0]        peer_slot
);
  import pqrl_pkg::*;

  localparam int SLOT_W = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
  localparam int USED_W = $clog2(PEER_ENTRIES + 1);

  // Captured transaction
  logic               in_op;
  logic [KEY_W-1:0]   in_key;
  logic [SIZE_W-1:0]  in_size;
  logic [TIME_W-1:0]  in_now;

  logic [SLOT_W-1:0]  addr;
  logic [SLOT_W-1:0]  slot;
  logic [USED_W-1:0]  slots_used;

  entry_t             mem [PEER_ENTRIES];
  entry_t             rd_data;
  entry_t             rec;
  entry_t             rec_next;
  entry_t             fresh;
  logic [STAT_W-1:0]  exec_status;

  logic [TIME_W-1:0]  diff;
  logic               restart;
  logic [CNT_W-1:0]   hits_eff;
  logic [TIME_W-1:0]  start_eff;
  logic [BYTES_W:0]   bytes_sum;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op   <= operation;
      in_key  <= peer_key;
      in_size <= tx_size;
      in_now  <= now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr <= '0;
    end else if (cmd.addr_inc) begin
      addr <= addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (cmd.load_new) begin
      slots_used <= slots_used + 1'b1;
    end
  end

  // Table memory: one read port for the scan, one write port for write-back
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      mem[slot] <= rec_next;
    end
  end

  always_comb begin
    fresh           = '0;
    fresh.key       = in_key;
    fresh.win_start = in_now;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hit) begin
      rec  <= rd_data;
      slot <= addr;
    end else if (cmd.load_new) begin
      rec  <= fresh;
      slot <= slots_used[SLOT_W-1:0];
    end
  end

  assign st.key_match  = (rd_data.key == in_key);
  assign st.last_entry = ((USED_W'(addr) + 1'b1) == slots_used);
  assign st.empty      = (slots_used == '0);
  assign st.table_full = (slots_used == USED_W'(PEER_ENTRIES));

  // Window restart when the signed time difference is at least one
  assign diff      = in_now - rec.win_start;
  assign restart   = (diff != '0) && !diff[TIME_W-1];
  assign hits_eff  = restart ? '0 : rec.hits;
  assign start_eff = restart ? in_now : rec.win_start;
  assign bytes_sum = {1'b0, rec.bytes} + (BYTES_W+1)'(in_size);

  always_comb begin
    rec_next    = rec;
    exec_status = ST_OK;
    if (in_op == OP_RESERVE) begin
      rec_next.hits      = hits_eff;
      rec_next.win_start = start_eff;
      if (hits_eff >= rate_limit) begin
        exec_status = ST_RATE;
      end else if (rec.items >= count_limit) begin
        exec_status = ST_COUNT;
      end else if (bytes_sum > {1'b0, max_bytes}) begin
        exec_status = ST_BYTES;
      end else begin
        rec_next.items = rec.items + 1'b1;
        rec_next.bytes = bytes_sum[BYTES_W-1:0];
        rec_next.hits  = hits_eff + 1'b1;
      end
    end else begin
      if (rec.items != '0) begin
        rec_next.items = rec.items - 1'b1;
      end
      if (rec.bytes >= BYTES_W'(in_size)) begin
        rec_next.bytes = rec.bytes - BYTES_W'(in_size);
      end
      if (rec.hits != '0) begin
        rec_next.hits = rec.hits - 1'b1;
      end
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec | cmd.full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status    <= exec_status;
      peer_slot <= slot_ext[SLOT_OUT_W-1:0];
    end else if (cmd.full) begin
      status    <= ST_FULL;
      peer_slot <= '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/peer_quota_rate_limiter_unit.sv
`default_nettype none

// Flow: the key scan reads and compares the used entries in order; a peer that is found is
// updated in its entry, a new peer is created in the next free slot, and a full table is reported.
// Throughput: one transaction at a time, with the sequential key scan reading and comparing one
// entry at a time through the single table read port. A new transaction is accepted in the
// cycle its predecessor's result is shown; results cannot be stalled.
// Reset: synchronous; empties the peer table (fill count to zero) and loads register defaults.

module peer_quota_rate_limiter_unit #(
  parameter int PEER_ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // transaction port
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              operation,
  input  wire logic signed [pqrl_pkg::KEY_W-1:0] peer_key,
  input  wire logic [pqrl_pkg::SIZE_W-1:0]       tx_size,
  input  wire logic [pqrl_pkg::TIME_W-1:0]       now_seconds,
  // result port
  output logic                                   done,
  output logic [pqrl_pkg::STAT_W-1:0]            status,
  output logic [pqrl_pkg::SLOT_OUT_W-1:0]        peer_slot,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [4:0]                        paddr,
  input  wire logic [63:0]                       pwdata,
  output logic [63:0]                            prdata,
  output logic                                   pready
);
  import pqrl_pkg::*;

  logic [CNT_W-1:0]   rate_limit;
  logic [CNT_W-1:0]   count_limit;
  logic [BYTES_W-1:0] max_bytes;
  logic               reg_wr;
  logic [1:0]         reg_idx;
  cmd_t               cmd;
  stat_t              st;

  // Registers sit at 8-byte strides; the low address bits are ignored.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit  <= MAX_RATE_RST;
      count_limit <= MAX_COUNT_RST;
      max_bytes   <= MAX_BYTES_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_MAX_RATE:  rate_limit  <= pwdata[CNT_W-1:0];
        REG_MAX_COUNT: count_limit <= pwdata[CNT_W-1:0];
        REG_MAX_BYTES: max_bytes   <= pwdata[BYTES_W-1:0];
        default: begin
          // drop writes outside the register list
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended to the bus width
  always_comb begin
    case (reg_idx)
      REG_MAX_RATE:  prdata = {{(64-CNT_W){1'b0}}, rate_limit};
      REG_MAX_COUNT: prdata = {{(64-CNT_W){1'b0}}, count_limit};
      REG_MAX_BYTES: prdata = {{(64-BYTES_W){1'b0}}, max_bytes};
      default:       prdata = '0;
    endcase
  end

  // Controller: walks the used entries, then creates, updates or reports full
  pqrl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // Datapath: peer table memory, working entry, limit checks and result register
  pqrl_datapath #(
    .PEER_ENTRIES (PEER_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .operation   (operation),
    .peer_key    (peer_key),
    .tx_size     (tx_size),
    .now_seconds (now_seconds),
    .rate_limit  (rate_limit),
    .count_limit (count_limit),
    .max_bytes   (max_bytes),
    .done        (done),
    .status      (status),
    .peer_slot   (peer_slot)
  );

endmodule

`default_nettype wire

>>> rtl/pqrl_checker.sv
`default_nettype none

module pqrl_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                done,
  input wire logic [pqrl_pkg::STAT_W-1:0]         status,
  input wire logic [pqrl_pkg::SLOT_OUT_W-1:0]     peer_slot
);
  import pqrl_pkg::*;

  // An accepted transaction keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after accepting a transaction");

  // Busy only rises from an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // A result is shown once the unit is free again, and lasts one cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && !$past(done)))
    else $error("result strobe while busy or repeated");

  // A full table reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (peer_slot == '0))
    else $error("table-full result with nonzero slot");

endmodule

bind peer_quota_rate_limiter_unit pqrl_checker u_pqrl_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .peer_slot (peer_slot)
);

`default_nettype wire
